/* hdl/doubly_linked_list_with_cursor_top_assert.svh */
// assertion macros for the linked list block
// used by the top level only, needs clk and rst in scope
`ifndef DOUBLY_LINKED_LIST_WITH_CURSOR_TOP_ASSERT_SVH
`define DOUBLY_LINKED_LIST_WITH_CURSOR_TOP_ASSERT_SVH

// same-cycle implication
`define DLLC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DLLC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/dllc_pkg.sv */
// shared types and codes for the linked list block
// no dependencies
package dllc_pkg;

  localparam int DLLC_POOL_DEPTH = 256;
  localparam int DLLC_DATA_WIDTH = 32;
  localparam int S_TDATA_W       = 40;
  localparam int M_TDATA_W       = 40;

  // command codes
  localparam logic [4:0] CMD_CLEAR      = 5'd0;
  localparam logic [4:0] CMD_INS_HEAD   = 5'd1;
  localparam logic [4:0] CMD_INS_TAIL   = 5'd2;
  localparam logic [4:0] CMD_CUR_HEAD   = 5'd3;
  localparam logic [4:0] CMD_CUR_TAIL   = 5'd4;
  localparam logic [4:0] CMD_RD_HEAD    = 5'd5;
  localparam logic [4:0] CMD_RD_TAIL    = 5'd6;
  localparam logic [4:0] CMD_DEL_HEAD   = 5'd7;
  localparam logic [4:0] CMD_DEL_TAIL   = 5'd8;
  localparam logic [4:0] CMD_DEL_AFTER  = 5'd9;
  localparam logic [4:0] CMD_DEL_BEFORE = 5'd10;
  localparam logic [4:0] CMD_INS_AFTER  = 5'd11;
  localparam logic [4:0] CMD_INS_BEFORE = 5'd12;
  localparam logic [4:0] CMD_RD_CUR     = 5'd13;
  localparam logic [4:0] CMD_WR_CUR     = 5'd14;
  localparam logic [4:0] CMD_NEXT       = 5'd15;
  localparam logic [4:0] CMD_PREV       = 5'd16;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic rd1;
    logic rd2;
    logic wr1;
    logic wr2;
    logic load;
  } dllc_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } dllc_stat_t;

endpackage

/* hdl/dllc_ctrl.sv */
// sequencer for one list request: two reads, two writes, result load
// depends on dllc_pkg
module dllc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  dllc_pkg::dllc_stat_t stat,
  output dllc_pkg::dllc_ctl_t  ctl
);
  import dllc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD1  = 3'd1;
  localparam logic [2:0] ST_RD2  = 3'd2;
  localparam logic [2:0] ST_WR1  = 3'd3;
  localparam logic [2:0] ST_WR2  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_RD1;
      ST_RD1:  state_next = ST_RD2;
      ST_RD2:  state_next = ST_WR1;
      ST_WR1:  state_next = ST_WR2;
      ST_WR2:  state_next = ST_DONE;
      ST_DONE: if (stat.out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // commands to the datapath
  assign s_tready   = (state == ST_IDLE);
  assign ctl.accept = (state == ST_IDLE) && s_tvalid;
  assign ctl.rd1    = (state == ST_RD1);
  assign ctl.rd2    = (state == ST_RD2);
  assign ctl.wr1    = (state == ST_WR1);
  assign ctl.wr2    = (state == ST_WR2);
  assign ctl.load   = (state == ST_DONE) && stat.out_free;

endmodule

/* hdl/dllc_dp.sv */
// node pool memories, list pointers, free list and result register
// depends on dllc_pkg
module dllc_dp #(
  parameter int POOL_DEPTH = dllc_pkg::DLLC_POOL_DEPTH,
  parameter int DATA_WIDTH = dllc_pkg::DLLC_DATA_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dllc_pkg::dllc_ctl_t           ctl,
  input  logic [dllc_pkg::S_TDATA_W-1:0] s_tdata,
  output dllc_pkg::dllc_stat_t          stat,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [dllc_pkg::M_TDATA_W-1:0] m_tdata
);
  import dllc_pkg::*;

  localparam int PW = $clog2(POOL_DEPTH + 1);
  localparam int AW = $clog2(POOL_DEPTH);
  localparam logic [PW-1:0] NIL = PW'(POOL_DEPTH);

  // pool memories
  logic [DATA_WIDTH-1:0] node_data [POOL_DEPTH];
  logic [PW-1:0]         node_next [POOL_DEPTH];
  logic [PW-1:0]         node_prev [POOL_DEPTH];

  logic [DATA_WIDTH-1:0] mem_data_q;
  logic [PW-1:0]         mem_next_q;
  logic [PW-1:0]         mem_prev_q;

  // request and list state
  logic [4:0]  cmd_q;
  logic [31:0] val_q;
  logic [PW-1:0] head, tail, cur, free_h, fresh;
  logic [PW-1:0] head_next, tail_next, cur_next, free_h_next, fresh_next;
  logic [PW-1:0] r1_next, r1_prev;
  logic [DATA_WIDTH-1:0] r1_data;

  // result
  logic [31:0] res_value, res_value_next;
  logic [1:0]  res_status, res_status_next;

  // second write set
  logic          w2_nx_en, w2_pv_en;
  logic [PW-1:0] w2_nx_addr, w2_nx_wd, w2_pv_addr, w2_pv_wd;
  logic          w2_nx_en_next, w2_pv_en_next;
  logic [PW-1:0] w2_nx_addr_next, w2_nx_wd_next, w2_pv_addr_next, w2_pv_wd_next;

  // first write set
  logic          p_nx_we, p_pv_we, p_dt_we;
  logic [PW-1:0] p_nx_wa, p_nx_wd, p_pv_wa, p_pv_wd, p_dt_wa;

  // muxed write ports
  logic          nx_we, pv_we, dt_we;
  logic [PW-1:0] nx_wa, nx_wd, pv_wa, pv_wd, dt_wa;
  logic [PW-1:0] raddr;

  logic [63:0] val_ext, rd_ext;
  logic [DATA_WIDTH-1:0] wr_data;

  logic [PW-1:0] n_node, lk_a, lk_b, del_p;
  logic          ins_cmd, ins_ok, del_ok;

  assign val_ext = {32'd0, val_q};
  assign wr_data = val_ext[DATA_WIDTH-1:0];

  always_comb begin
    rd_ext = '0;
    rd_ext[DATA_WIDTH-1:0] = r1_data;
  end

  // read address for each read step
  always_comb begin
    raddr = cur;
    if (ctl.rd1) begin
      priority case (cmd_q)
        CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AFTER, CMD_INS_BEFORE: raddr = free_h;
        CMD_RD_HEAD, CMD_DEL_HEAD: raddr = head;
        CMD_RD_TAIL, CMD_DEL_TAIL: raddr = tail;
        default: raddr = cur;
      endcase
    end else begin
      priority case (cmd_q)
        CMD_DEL_HEAD:   raddr = head;
        CMD_DEL_TAIL:   raddr = tail;
        CMD_DEL_AFTER:  raddr = mem_next_q;
        CMD_DEL_BEFORE: raddr = mem_prev_q;
        default:        raddr = cur;
      endcase
    end
  end

  // first write step and pointer updates
  always_comb begin
    head_next = head; tail_next = tail; cur_next = cur;
    free_h_next = free_h; fresh_next = fresh;
    res_value_next = 32'd0; res_status_next = STAT_OK;
    p_nx_we = 1'b0; p_nx_wa = free_h; p_nx_wd = free_h;
    p_pv_we = 1'b0; p_pv_wa = free_h; p_pv_wd = free_h;
    p_dt_we = 1'b0; p_dt_wa = cur;
    w2_nx_en_next = 1'b0; w2_nx_addr_next = NIL; w2_nx_wd_next = NIL;
    w2_pv_en_next = 1'b0; w2_pv_addr_next = NIL; w2_pv_wd_next = NIL;
    n_node = NIL; lk_a = NIL; lk_b = NIL; del_p = NIL;
    ins_cmd = 1'b0; ins_ok = 1'b0; del_ok = 1'b0;

    priority case (cmd_q)
      CMD_INS_HEAD:   begin ins_cmd = 1'b1; lk_a = NIL; lk_b = head; end
      CMD_INS_TAIL:   begin ins_cmd = 1'b1; lk_a = tail; lk_b = NIL; end
      CMD_INS_AFTER:  begin ins_cmd = (cur != NIL); lk_a = cur; lk_b = mem_next_q; end
      CMD_INS_BEFORE: begin ins_cmd = (cur != NIL); lk_a = mem_prev_q; lk_b = cur; end
      CMD_DEL_HEAD:   begin del_p = head; del_ok = (head != NIL); end
      CMD_DEL_TAIL:   begin del_p = tail; del_ok = (tail != NIL); end
      CMD_DEL_AFTER:  begin del_p = r1_next; del_ok = (cur != NIL) && (r1_next != NIL); end
      CMD_DEL_BEFORE: begin del_p = r1_prev; del_ok = (cur != NIL) && (r1_prev != NIL); end
      default: ;
    endcase

    // node allocation: free list first, then never-used nodes
    if (ins_cmd) begin
      if (free_h != NIL) begin
        n_node = free_h; free_h_next = r1_next; ins_ok = 1'b1;
      end else if (fresh != NIL) begin
        n_node = fresh; fresh_next = fresh + PW'(1); ins_ok = 1'b1;
      end else begin
        res_status_next = STAT_FULL;
      end
    end

    if (ins_ok) begin
      p_dt_we = 1'b1; p_dt_wa = n_node;
      p_nx_we = 1'b1; p_nx_wa = n_node; p_nx_wd = lk_b;
      p_pv_we = 1'b1; p_pv_wa = n_node; p_pv_wd = lk_a;
      if (lk_a == NIL) head_next = n_node;
      if (lk_b == NIL) tail_next = n_node;
      w2_nx_en_next = (lk_a != NIL); w2_nx_addr_next = lk_a; w2_nx_wd_next = n_node;
      w2_pv_en_next = (lk_b != NIL); w2_pv_addr_next = lk_b; w2_pv_wd_next = n_node;
    end

    // unlink: neighbors come from the second read
    if (del_ok) begin
      p_nx_we = 1'b1; p_nx_wa = del_p; p_nx_wd = free_h;
      free_h_next = del_p;
      if (mem_prev_q == NIL) head_next = mem_next_q;
      if (mem_next_q == NIL) tail_next = mem_prev_q;
      if (cur == del_p) cur_next = NIL;
      w2_nx_en_next = (mem_prev_q != NIL);
      w2_nx_addr_next = mem_prev_q; w2_nx_wd_next = mem_next_q;
      w2_pv_en_next = (mem_next_q != NIL);
      w2_pv_addr_next = mem_next_q; w2_pv_wd_next = mem_prev_q;
    end

    priority case (cmd_q)
      CMD_CLEAR: begin
        if (head != NIL) begin
          p_nx_we = 1'b1; p_nx_wa = tail; p_nx_wd = free_h;
          free_h_next = head;
        end
        head_next = NIL; tail_next = NIL; cur_next = NIL;
      end
      CMD_CUR_HEAD: cur_next = head;
      CMD_CUR_TAIL: cur_next = tail;
      CMD_RD_HEAD: begin
        if (head == NIL) res_status_next = STAT_EMPTY;
        else res_value_next = rd_ext[31:0];
      end
      CMD_RD_TAIL: begin
        if (tail == NIL) res_status_next = STAT_EMPTY;
        else res_value_next = rd_ext[31:0];
      end
      CMD_RD_CUR: begin
        if (cur == NIL) res_status_next = STAT_EMPTY;
        else res_value_next = rd_ext[31:0];
      end
      CMD_WR_CUR: begin
        p_dt_we = (cur != NIL); p_dt_wa = cur;
      end
      CMD_NEXT: if (cur != NIL) cur_next = r1_next;
      CMD_PREV: if (cur != NIL) cur_next = r1_prev;
      default: ;
    endcase
  end

  // write port selection
  always_comb begin
    nx_we = 1'b0; nx_wa = p_nx_wa; nx_wd = p_nx_wd;
    pv_we = 1'b0; pv_wa = p_pv_wa; pv_wd = p_pv_wd;
    dt_we = ctl.wr1 && p_dt_we; dt_wa = p_dt_wa;
    if (ctl.wr1) begin
      nx_we = p_nx_we; pv_we = p_pv_we;
    end else if (ctl.wr2) begin
      nx_we = w2_nx_en; nx_wa = w2_nx_addr; nx_wd = w2_nx_wd;
      pv_we = w2_pv_en; pv_wa = w2_pv_addr; pv_wd = w2_pv_wd;
    end
  end

  // pool memories, one write and one registered read each
  always_ff @(posedge clk) begin
    if (nx_we) node_next[nx_wa[AW-1:0]] <= nx_wd;
    if (pv_we) node_prev[pv_wa[AW-1:0]] <= pv_wd;
    if (dt_we) node_data[dt_wa[AW-1:0]] <= wr_data;
    mem_next_q <= node_next[raddr[AW-1:0]];
    mem_prev_q <= node_prev[raddr[AW-1:0]];
    mem_data_q <= node_data[raddr[AW-1:0]];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_q <= s_tdata[4:0];
      val_q <= s_tdata[36:5];
    end
    if (ctl.rd2) begin
      r1_next <= mem_next_q;
      r1_prev <= mem_prev_q;
      r1_data <= mem_data_q;
    end
    if (ctl.wr1) begin
      res_value  <= res_value_next;
      res_status <= res_status_next;
      w2_nx_en <= w2_nx_en_next; w2_nx_addr <= w2_nx_addr_next; w2_nx_wd <= w2_nx_wd_next;
      w2_pv_en <= w2_pv_en_next; w2_pv_addr <= w2_pv_addr_next; w2_pv_wd <= w2_pv_wd_next;
    end
    if (ctl.load) begin
      m_tdata <= {4'd0, (head == NIL), (cur != NIL), res_status, res_value};
    end
  end

  // list pointers and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= NIL; tail <= NIL; cur <= NIL; free_h <= NIL;
      fresh <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (ctl.wr1) begin
        head <= head_next; tail <= tail_next; cur <= cur_next;
        free_h <= free_h_next; fresh <= fresh_next;
      end
      if (ctl.load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  assign stat.out_free = !m_tvalid || m_tready;

endmodule

/* hdl/doubly_linked_list_with_cursor_top.sv */
// linked list with cursor over a node pool: top level, joins dllc_ctrl and dllc_dp
// one request at a time: two pool reads, two write steps, then the result load;
// the next request is accepted once the result is loaded into the output register
// result held in an output register until taken; a full output stalls only at the end
// rst (sync, active high) empties the list, free list and fresh count; pool contents undefined
// depends on dllc_pkg and doubly_linked_list_with_cursor_top_assert.svh
`include "doubly_linked_list_with_cursor_top_assert.svh"
module doubly_linked_list_with_cursor_top #(
  parameter int POOL_DEPTH = dllc_pkg::DLLC_POOL_DEPTH,
  parameter int DATA_WIDTH = dllc_pkg::DLLC_DATA_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // command [4:0], value [36:5], zero [39:37]
  input  logic [dllc_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // read_value [31:0], status [33:32], cursor_valid [34], list_empty [35], zero [39:36]
  output logic [dllc_pkg::M_TDATA_W-1:0] m_tdata
);
  import dllc_pkg::*;

  dllc_ctl_t  ctl;
  dllc_stat_t stat;

  dllc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .ctl      (ctl)
  );

  dllc_dp #(
    .POOL_DEPTH (POOL_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .s_tdata  (s_tdata),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // a request blocks further requests while it is being worked on
  `DLLC_ASSERT_NXT(a_busy_after_req, s_tvalid && s_tready, !s_tready, "request accepted while busy")
  // an empty list cannot hold a cursor
  `DLLC_ASSERT_IMP(a_empty_no_cursor, m_tvalid, !(m_tdata[35] && m_tdata[34]), "cursor on empty list")
  // status code stays in range
  `DLLC_ASSERT_IMP(a_status_range, m_tvalid, m_tdata[33:32] != 2'd3, "bad status code")

endmodule
